// ===== rtl/core/ptz_pkg.sv =====
// shared types and constants of the ptz command frame encoder
package ptz_pkg;

	// frame geometry
	localparam int FRAME_MAX = 11;
	localparam int LEN_W     = 4;

	// protocol codes
	localparam logic [1:0] PROTO_ELEVEN  = 2'd0;
	localparam logic [1:0] PROTO_PELCO_D = 2'd1;
	localparam logic [1:0] PROTO_PELCO_P = 2'd2;
	localparam logic [1:0] PROTO_NONE    = 2'd3;

	// action codes, anything above focus in means stop
	localparam logic [3:0] ACT_PAN_RIGHT = 4'd0;
	localparam logic [3:0] ACT_PAN_LEFT  = 4'd1;
	localparam logic [3:0] ACT_TILT_UP   = 4'd2;
	localparam logic [3:0] ACT_TILT_DOWN = 4'd3;
	localparam logic [3:0] ACT_ZOOM_IN   = 4'd4;
	localparam logic [3:0] ACT_ZOOM_OUT  = 4'd5;
	localparam logic [3:0] ACT_FOCUS_OUT = 4'd6;
	localparam logic [3:0] ACT_FOCUS_IN  = 4'd7;

	// frame lengths
	localparam logic [LEN_W-1:0] LEN_ELEVEN  = 4'd11;
	localparam logic [LEN_W-1:0] LEN_PELCO_D = 4'd7;
	localparam logic [LEN_W-1:0] LEN_PELCO_P = 4'd8;

	// fixed frame bytes
	localparam logic [7:0] SYNC_ELEVEN   = 8'h55;
	localparam logic [7:0] END_ELEVEN    = 8'hAA;
	localparam logic [7:0] CSUM_BASE     = 8'h20;
	localparam logic [7:0] SYNC_PELCO_D  = 8'hFF;
	localparam logic [7:0] STX_PELCO_P   = 8'hA0;
	localparam logic [7:0] ETX_PELCO_P   = 8'hAF;
	localparam logic [7:0] SPD_PAN_ELV   = 8'hB0;
	localparam logic [7:0] SPD_TILT_ELV  = 8'hBF;
	localparam logic [7:0] SPD_LENS_ELV  = 8'h05;
	localparam logic [7:0] SPD_PELCO     = 8'h20;

	// command bit patterns
	localparam logic [7:0] CMD_PAN_RIGHT = 8'h02;
	localparam logic [7:0] CMD_PAN_LEFT  = 8'h04;
	localparam logic [7:0] CMD_TILT_UP   = 8'h08;
	localparam logic [7:0] CMD_TILT_DOWN = 8'h10;
	localparam logic [7:0] CMD_ZOOM_IN   = 8'h20;
	localparam logic [7:0] CMD_ZOOM_OUT  = 8'h40;
	localparam logic [7:0] CMD_FOCUS_A   = 8'h01;
	localparam logic [7:0] CMD_FOCUS_B   = 8'h02;
	localparam logic [7:0] CMD_FOCUS_D   = 8'h80;

	// byte 0 goes out first
	typedef logic [FRAME_MAX-1:0][7:0] frame_bytes_t;

	typedef struct packed {
		frame_bytes_t     bytes;
		logic [LEN_W-1:0] len;
	} frame_t;

endpackage

// ===== rtl/core/ptz_frame_build.sv =====
// builds the complete frame and checksum for one command
module ptz_frame_build import ptz_pkg::*; (
	input  logic [1:0] protocol,
	input  logic [3:0] action,
	input  logic [7:0] target_address,
	output frame_t     frame
);

	frame_bytes_t b;
	logic [7:0]   sum_elv;
	logic [7:0]   sum_d;
	logic [7:0]   xor_p;
	logic [LEN_W-1:0] len;

	// frame body per protocol
	always_comb begin
		b   = '0;
		len = '0;
		case (protocol)
			PROTO_ELEVEN: begin
				len  = LEN_ELEVEN;
				b[0] = SYNC_ELEVEN;
				b[2] = target_address;
				b[9] = END_ELEVEN;
				case (action)
					ACT_PAN_RIGHT: begin b[4] = CMD_PAN_RIGHT; b[5] = SPD_PAN_ELV; end
					ACT_PAN_LEFT:  begin b[4] = CMD_PAN_LEFT;  b[5] = SPD_PAN_ELV; end
					ACT_TILT_UP:   begin b[4] = CMD_TILT_UP;   b[6] = SPD_TILT_ELV; end
					ACT_TILT_DOWN: begin b[4] = CMD_TILT_DOWN; b[6] = SPD_TILT_ELV; end
					ACT_ZOOM_IN:   begin b[4] = CMD_ZOOM_IN;   b[7] = SPD_LENS_ELV; end
					ACT_ZOOM_OUT:  begin b[4] = CMD_ZOOM_OUT;  b[7] = SPD_LENS_ELV; end
					ACT_FOCUS_OUT: begin b[3] = CMD_FOCUS_A;   b[7] = SPD_LENS_ELV; end
					ACT_FOCUS_IN:  begin b[3] = CMD_FOCUS_B;   b[7] = SPD_LENS_ELV; end
					default: ;
				endcase
			end
			PROTO_PELCO_D, PROTO_PELCO_P: begin
				if (protocol == PROTO_PELCO_D) begin
					len  = LEN_PELCO_D;
					b[0] = SYNC_PELCO_D;
				end else begin
					len  = LEN_PELCO_P;
					b[0] = STX_PELCO_P;
					b[6] = ETX_PELCO_P;
				end
				b[1] = target_address;
				case (action)
					ACT_PAN_RIGHT: begin b[3] = CMD_PAN_RIGHT; b[4] = SPD_PELCO; end
					ACT_PAN_LEFT:  begin b[3] = CMD_PAN_LEFT;  b[4] = SPD_PELCO; end
					ACT_TILT_UP:   begin b[3] = CMD_TILT_UP;   b[5] = SPD_PELCO; end
					ACT_TILT_DOWN: begin b[3] = CMD_TILT_DOWN; b[5] = SPD_PELCO; end
					ACT_ZOOM_IN:   b[3] = CMD_ZOOM_IN;
					ACT_ZOOM_OUT:  b[3] = CMD_ZOOM_OUT;
					ACT_FOCUS_OUT: begin
						if (protocol == PROTO_PELCO_D) b[3] = CMD_FOCUS_D;
						else b[2] = CMD_FOCUS_A;
					end
					ACT_FOCUS_IN: begin
						if (protocol == PROTO_PELCO_D) b[2] = CMD_FOCUS_A;
						else b[2] = CMD_FOCUS_B;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// checksums, modulo 256 by truncation
	assign sum_elv = CSUM_BASE - (((b[0] + b[2]) + (b[3] + b[4]))
		+ ((b[5] + b[6]) + (b[7] + b[9])));
	assign sum_d   = (b[1] + b[2]) + (b[3] + b[4]) + b[5];
	assign xor_p   = b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5];

	// place the checksum as the last byte
	always_comb begin
		frame.bytes = b;
		frame.len   = len;
		case (protocol)
			PROTO_ELEVEN:  frame.bytes[10] = sum_elv;
			PROTO_PELCO_D: frame.bytes[6]  = sum_d;
			PROTO_PELCO_P: frame.bytes[7]  = xor_p;
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/ptz_byte_serializer.sv =====
// frame shift register that sends one byte per output beat
module ptz_byte_serializer import ptz_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  frame_t     frame,
	output logic       free,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // frame_byte [7:0]
	output logic       m_tlast
);

	frame_bytes_t     sh_q;
	logic [LEN_W-1:0] rem_q;
	logic             beat;

	assign beat     = m_tvalid && m_tready;
	assign m_tvalid = (rem_q != '0);
	assign m_tlast  = (rem_q == LEN_W'(1));
	assign m_tdata  = sh_q[0];
	// ready for a new frame when empty or the last byte leaves now
	assign free     = !m_tvalid || (m_tlast && m_tready);

	// remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= frame.len;
		end else if (beat) begin
			rem_q <= rem_q - LEN_W'(1);
		end
	end

	// byte shift line, payload only
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= frame.bytes;
		end else if (beat) begin
			sh_q <= sh_q >> 8;
		end
	end

endmodule

// ===== rtl/core/ptz_command_frame_encoder_unit.sv =====
// top level of the ptz command frame encoder
// Each accepted command beat yields its serial frame on the master side, one byte per
// beat with tlast on the checksum byte: 11 beats for the eleven-byte protocol, 7 for
// Pelco-D, 8 for Pelco-P, none for protocol 3. The output byte shifter sets the rate, and
// a protocol-3 command is dropped from the command register without reaching it. With
// the output idle, an accepted command is held in the command register and then loaded
// into the byte shifter, which presents the first byte. The command register takes the
// next command while the current frame is still being sent, and the next frame follows its
// predecessor with no idle cycle. The block holds no state between commands.
module ptz_command_frame_encoder_unit import ptz_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // protocol [1:0], action [5:2], target_address [13:6]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // frame_byte [7:0]
	output logic        m_tlast    // last_byte
);

	logic       valid_s1;
	logic [1:0] protocol_s1;
	logic [3:0] action_s1;
	logic [7:0] target_address_s1;
	logic       s_beat;
	logic       ser_free;
	logic       ser_load;
	logic       s1_done;
	frame_t     frame;

	// command register handshake
	assign s_beat   = s_tvalid && s_tready;
	assign ser_load = valid_s1 && (protocol_s1 != PROTO_NONE) && ser_free;
	assign s1_done  = valid_s1 && ((protocol_s1 == PROTO_NONE) || ser_free);
	assign s_tready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_beat) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (s_beat) begin
			protocol_s1       <= s_tdata[1:0];
			action_s1         <= s_tdata[5:2];
			target_address_s1 <= s_tdata[13:6];
		end
	end

	// frame assembly
	ptz_frame_build u_build (
		.protocol       (protocol_s1),
		.action         (action_s1),
		.target_address (target_address_s1),
		.frame          (frame)
	);

	// byte output
	ptz_byte_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ser_load),
		.frame    (frame),
		.free     (ser_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// a frame is only loaded once the previous one is gone or finishing
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ser_load |-> (!m_tvalid || (m_tlast && m_tready)))
		else $error("frame loaded over a frame in flight");

	// a freshly loaded frame has more than one byte
	a_load_len: assert property (@(posedge clk) disable iff (!arst_n)
		ser_load |=> (m_tvalid && !m_tlast))
		else $error("loaded frame too short");

	// a frame is never cut short
	a_no_cut: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("frame ended without last byte");

	// a protocol 3 command never reaches the output
	a_drop_none: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (protocol_s1 == PROTO_NONE)) |-> !ser_load)
		else $error("unknown protocol produced a frame");

endmodule
